// ----- hdl/lfht_pkg.sv -----
// Package for the lowest-free handle table: sizes, request/status codes,
// sequencer states and the per-slot record layout.
// No dependencies.
package lfht_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  // Allocation scan looks at one group of slots per cycle
  localparam int GROUP  = 8;
  localparam int GRP_W  = $clog2(GROUP);
  localparam int NGRP   = (SLOT_COUNT + GROUP - 1) / GROUP;
  localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_W  = NGRP * GROUP;

  typedef enum logic [2:0] {
    REQ_ALLOC     = 3'd0,
    REQ_ALLOC_RES = 3'd1,
    REQ_FREE      = 3'd2,
    REQ_RD_MOUNT  = 3'd3,
    REQ_RD_INODE  = 3'd4,
    REQ_WR_INODE  = 3'd5,
    REQ_RD_OFFSET = 3'd6,
    REQ_WR_OFFSET = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_RANGE = 2'd1,
    RES_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_MOD,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [7:0]  mount;
    logic [31:0] inode;
    logic [62:0] offset;
  } row_t;

endpackage

// ----- hdl/lowest_free_handle_table_top.sv -----
// Lowest-free handle table: slot status bitmaps, search hint and sequencer;
// slot records live in one lfht_ram instance. Depends on lfht_pkg, lfht_ram.
//
// One request is handled at a time. A non-alloc request with a valid handle
// passes through RAM read, registered read data merged and written back, then
// the response register; the block accepts no new request until it returns
// to idle. An alloc first scans the availability bitmap upward from the
// search hint, 8 slots per cycle, before the same steps. Out-of-range handles
// and a full table answer without touching the RAM. A finished result waits
// in the output register while the next request is accepted; a second result
// that finds that register still held stays in the response step and blocks
// the input until the reply is taken. Slot records reset to zero through one
// valid bit per slot, so no clearing pass is needed after reset.
module lowest_free_handle_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  handle_i,
  input  logic [7:0]  mount_id_i,
  input  logic [31:0] inode_value_i,
  input  logic [62:0] offset_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  handle_out_o,
  output logic [7:0]  mount_out_o,
  output logic [31:0] inode_out_o,
  output logic [62:0] offset_out_o
);

  // control state
  lfht_pkg::state_e                   state_q, state_d;
  logic [lfht_pkg::SLOT_COUNT-1:0]    used_q, used_d;
  logic [lfht_pkg::SLOT_COUNT-1:0]    rsv_q, rsv_d;
  logic [lfht_pkg::SLOT_COUNT-1:0]    vld_q, vld_d;
  logic [lfht_pkg::SLOT_W-1:0]        hint_q, hint_d;
  logic                               out_valid_q, out_valid_d;

  // request and result payload
  lfht_pkg::req_e                     req_q, req_d;
  logic [lfht_pkg::SLOT_W-1:0]        addr_q, addr_d;
  logic [7:0]                         mount_q, mount_d;
  logic [31:0]                        inode_q, inode_d;
  logic [62:0]                        offset_q, offset_d;
  logic [lfht_pkg::GIDX_W-1:0]        grp_q, grp_d;
  lfht_pkg::status_e                  res_status_q, res_status_d;
  logic [7:0]                         res_handle_q, res_handle_d;
  logic [7:0]                         res_mount_q, res_mount_d;
  logic [31:0]                        res_inode_q, res_inode_d;
  logic [62:0]                        res_offset_q, res_offset_d;
  lfht_pkg::status_e                  out_status_q, out_status_d;
  logic [7:0]                         out_handle_q, out_handle_d;
  logic [7:0]                         out_mount_q, out_mount_d;
  logic [31:0]                        out_inode_q, out_inode_d;
  logic [62:0]                        out_offset_q, out_offset_d;

  // scan unit
  logic [lfht_pkg::PAD_W-1:0]         avail_pad;
  logic [lfht_pkg::GROUP-1:0]         grp_bits;
  logic [lfht_pkg::GROUP-1:0]         cand;
  logic [lfht_pkg::GIDX_W+lfht_pkg::GRP_W-1:0] idx_k;
  logic [lfht_pkg::GRP_W-1:0]         hit_k;
  logic                               hit;
  logic [lfht_pkg::SLOT_W-1:0]        found_idx;

  // record RAM
  logic                               ram_we;
  lfht_pkg::row_t                     ram_wdata;
  logic [$bits(lfht_pkg::row_t)-1:0]  ram_rdata;
  lfht_pkg::row_t                     row_cur;
  logic                               handle_ok;

  lfht_ram #(
    .WIDTH($bits(lfht_pkg::row_t)),
    .DEPTH(lfht_pkg::SLOT_COUNT)
  ) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(ram_wdata),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  assign handle_ok = {1'b0, handle_i} < 9'(lfht_pkg::SLOT_COUNT);

  // Group of the availability bitmap under test, masked below the hint
  always_comb begin
    avail_pad = lfht_pkg::PAD_W'(~used_q & ~rsv_q);
    grp_bits  = avail_pad[grp_q*lfht_pkg::GROUP +: lfht_pkg::GROUP];
    for (int k = 0; k < lfht_pkg::GROUP; k++) begin
      idx_k   = {grp_q, lfht_pkg::GRP_W'(k)};
      cand[k] = grp_bits[k] &&
                (idx_k >= (lfht_pkg::GIDX_W + lfht_pkg::GRP_W)'(hint_q));
    end
    hit   = |cand;
    hit_k = '0;
    for (int k = lfht_pkg::GROUP - 1; k >= 0; k--) begin
      if (cand[k]) begin
        hit_k = lfht_pkg::GRP_W'(k);
      end
    end
    found_idx = lfht_pkg::SLOT_W'({grp_q, hit_k});
  end

  assign row_cur = vld_q[addr_q] ? lfht_pkg::row_t'(ram_rdata) : '0;

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    rsv_d        = rsv_q;
    vld_d        = vld_q;
    hint_d       = hint_q;
    req_d        = req_q;
    addr_d       = addr_q;
    mount_d      = mount_q;
    inode_d      = inode_q;
    offset_d     = offset_q;
    grp_d        = grp_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_mount_d  = res_mount_q;
    res_inode_d  = res_inode_q;
    res_offset_d = res_offset_q;
    out_status_d = out_status_q;
    out_handle_d = out_handle_q;
    out_mount_d  = out_mount_q;
    out_inode_d  = out_inode_q;
    out_offset_d = out_offset_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_wdata    = row_cur;

    case (state_q)
      lfht_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d        = lfht_pkg::req_e'(req_type_i);
          addr_d       = handle_i[lfht_pkg::SLOT_W-1:0];
          mount_d      = mount_id_i;
          inode_d      = inode_value_i;
          offset_d     = offset_value_i;
          grp_d        = lfht_pkg::GIDX_W'(hint_q >> lfht_pkg::GRP_W);
          res_status_d = lfht_pkg::RES_OK;
          res_handle_d = '0;
          res_mount_d  = '0;
          res_inode_d  = '0;
          res_offset_d = '0;
          if (lfht_pkg::req_e'(req_type_i) == lfht_pkg::REQ_ALLOC) begin
            state_d = lfht_pkg::ST_SCAN;
          end else if (!handle_ok) begin
            res_status_d = lfht_pkg::RES_RANGE;
            state_d      = lfht_pkg::ST_RESP;
          end else begin
            state_d = lfht_pkg::ST_RD;
          end
        end
      end
      lfht_pkg::ST_SCAN: begin
        if (hit) begin
          addr_d  = found_idx;
          state_d = lfht_pkg::ST_RD;
        end else if (grp_q == lfht_pkg::GIDX_W'(lfht_pkg::NGRP - 1)) begin
          res_status_d = lfht_pkg::RES_FULL;
          state_d      = lfht_pkg::ST_RESP;
        end else begin
          grp_d = grp_q + 1'b1;
        end
      end
      lfht_pkg::ST_RD: begin
        // read data for addr_q is registered at the end of this cycle
        state_d = lfht_pkg::ST_MOD;
      end
      lfht_pkg::ST_MOD: begin
        state_d = lfht_pkg::ST_RESP;
        case (req_q)
          lfht_pkg::REQ_ALLOC: begin
            ram_wdata.mount = mount_q;
            ram_we          = 1'b1;
            vld_d[addr_q]   = 1'b1;
            used_d[addr_q]  = 1'b1;
            hint_d          = addr_q;
            res_handle_d    = 8'(addr_q);
          end
          lfht_pkg::REQ_ALLOC_RES: begin
            ram_wdata.mount = mount_q;
            ram_we          = 1'b1;
            vld_d[addr_q]   = 1'b1;
            used_d[addr_q]  = 1'b0;
            rsv_d[addr_q]   = 1'b1;
            res_handle_d    = 8'(addr_q);
          end
          lfht_pkg::REQ_FREE: begin
            // reserved slots survive a free
            if (!rsv_q[addr_q]) begin
              used_d[addr_q] = 1'b0;
              vld_d[addr_q]  = 1'b0;
              if (addr_q < hint_q) begin
                hint_d = addr_q;
              end
            end
          end
          lfht_pkg::REQ_RD_MOUNT:  res_mount_d  = row_cur.mount;
          lfht_pkg::REQ_RD_INODE:  res_inode_d  = row_cur.inode;
          lfht_pkg::REQ_RD_OFFSET: res_offset_d = row_cur.offset;
          lfht_pkg::REQ_WR_INODE: begin
            ram_wdata.inode = inode_q;
            ram_we          = 1'b1;
            vld_d[addr_q]   = 1'b1;
          end
          lfht_pkg::REQ_WR_OFFSET: begin
            ram_wdata.offset = offset_q;
            ram_we           = 1'b1;
            vld_d[addr_q]    = 1'b1;
          end
          default: ;
        endcase
      end
      lfht_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_status_d = res_status_q;
          out_handle_d = res_handle_q;
          out_mount_d  = res_mount_q;
          out_inode_d  = res_inode_q;
          out_offset_d = res_offset_q;
          out_valid_d  = 1'b1;
          state_d      = lfht_pkg::ST_IDLE;
        end
      end
      default: state_d = lfht_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfht_pkg::ST_IDLE;
      used_q      <= '0;
      rsv_q       <= '0;
      vld_q       <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rsv_q       <= rsv_d;
      vld_q       <= vld_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    addr_q       <= addr_d;
    mount_q      <= mount_d;
    inode_q      <= inode_d;
    offset_q     <= offset_d;
    grp_q        <= grp_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_mount_q  <= res_mount_d;
    res_inode_q  <= res_inode_d;
    res_offset_q <= res_offset_d;
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
    out_mount_q  <= out_mount_d;
    out_inode_q  <= out_inode_d;
    out_offset_q <= out_offset_d;
  end

  assign in_ready_o   = (state_q == lfht_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign handle_out_o = out_handle_q;
  assign mount_out_o  = out_mount_q;
  assign inode_out_o  = out_inode_q;
  assign offset_out_o = out_offset_q;

`ifndef ASSERT_OFF
  // a slot is never used and reserved at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) (used_q & rsv_q) == '0)
    else $error("slot both used and reserved");

  // a new result only appears out of the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lfht_pkg::ST_RESP))
    else $error("result raised outside response state");

  // results carry only defined status codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == lfht_pkg::RES_OK || status_o == lfht_pkg::RES_RANGE ||
                     status_o == lfht_pkg::RES_FULL))
    else $error("undefined status code");

  // the record RAM is written only while finishing a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == lfht_pkg::ST_MOD && $past(state_q == lfht_pkg::ST_RD)))
    else $error("record write outside modify step");
`endif

endmodule

// ----- hdl/lfht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
